/* src/ldpt_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// LRU demand page translator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ldpt_pkg;

    // Geometry of the paging scheme.
    localparam int PAGE_BYTES  = 4096;
    localparam int NUM_BUFFERS = 16;
    localparam int NUM_DICTS   = 4;
    localparam int MAX_PAGES   = 1024;
    localparam int WORD_BYTES  = 8;

    // Field and storage widths.
    localparam int POS_W      = 24;
    localparam int LEN_W      = 23;
    localparam int OFFSET_W   = $clog2(PAGE_BYTES);
    localparam int WORD_SHIFT = $clog2(WORD_BYTES);
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int SLOT_W     = $clog2(NUM_BUFFERS);
    localparam int DICT_W     = $clog2(NUM_DICTS);
    localparam int ENTRY_W    = 1 + DICT_W + PAGE_W;
    localparam int MAP_DEPTH  = 2 * NUM_DICTS * MAX_PAGES;
    localparam int MAP_W      = 1 + SLOT_W;
    localparam int STAMP_W    = 48;

    // Configuration port.
    localparam int NUM_REGS = 4;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int PADDR_W  = REG_IDX_W + 2;
    localparam int PDATA_W  = 32;

    localparam logic [REG_IDX_W-1:0] REG_DICT_LEN_0 = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DICT_LEN_1 = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DICT_LEN_2 = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_DICT_LEN_3 = 2'd3;

    // Store kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_WORD = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic load;
        logic clear_wr;
        logic lookup;
        logic scan_init;
        logic scan_step;
        logic unmap;
        logic map;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic bad;
        logic lookup_hit;
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* src/ldpt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ldpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/ldpt_ctrl.sv */
// Controller state machine of the page translator: sequences the clearing
// pass, lookup, LRU scan, unmap, map and result hand-off. Uses ldpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldpt_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire ldpt_pkg::t_stat i_stat,
    output ldpt_pkg::t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_LOOKUP = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_UNMAP  = 7'b0010000,
        S_MAP    = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                if (i_stat.bad || i_stat.lookup_hit) begin
                    if (i_stat.out_free) begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_UNMAP;
                end
            end
            S_UNMAP: begin
                o_cmd.unmap = 1'b1;
                n_state     = S_MAP;
            end
            S_MAP: begin
                o_cmd.map = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/ldpt_dp.sv */
// Datapath of the page translator: address split, page map RAM, buffer
// owners, use stamps, LRU scan and the result register. Uses ldpt_pkg, ldpt_ram.
`timescale 1ns / 1ps
`default_nettype none

module ldpt_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ldpt_pkg::t_cmd                  i_cmd,
    output ldpt_pkg::t_stat                      o_stat,
    input  wire logic                            i_store_kind,
    input  wire logic [ldpt_pkg::DICT_W-1:0]     i_dict_select,
    input  wire logic [ldpt_pkg::POS_W-1:0]      i_position,
    input  wire logic [ldpt_pkg::LEN_W-1:0]      i_sel_len,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic                                 o_out_of_range,
    output logic                                 o_hit,
    output logic [ldpt_pkg::SLOT_W-1:0]          o_buffer_slot,
    output logic [ldpt_pkg::OFFSET_W-1:0]        o_page_offset,
    output logic [ldpt_pkg::PAGE_W-1:0]          o_fetch_page,
    output logic                                 o_evicted_valid,
    output logic [ldpt_pkg::DICT_W-1:0]          o_evicted_dict,
    output logic                                 o_evicted_kind,
    output logic [ldpt_pkg::PAGE_W-1:0]          o_evicted_page
);

    localparam int POS_W   = ldpt_pkg::POS_W;
    localparam int OFF_W   = ldpt_pkg::OFFSET_W;
    localparam int WSH     = ldpt_pkg::WORD_SHIFT;
    localparam int PAGE_W  = ldpt_pkg::PAGE_W;
    localparam int SLOT_W  = ldpt_pkg::SLOT_W;
    localparam int ENTRY_W = ldpt_pkg::ENTRY_W;
    localparam int MAP_W   = ldpt_pkg::MAP_W;
    localparam int STAMP_W = ldpt_pkg::STAMP_W;
    localparam int NBUF    = ldpt_pkg::NUM_BUFFERS;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NBUF - 1);

    // Address split of the incoming item.
    logic [POS_W-1:0]   w_pm1;
    logic [PAGE_W-1:0]  w_in_page;
    logic [OFF_W-1:0]   w_in_offset;
    logic               w_in_bad;
    logic [ENTRY_W-1:0] w_in_entry;

    always_comb begin
        w_pm1 = i_position - POS_W'(1);
        if (i_store_kind == ldpt_pkg::KIND_BYTE) begin
            w_in_page   = w_pm1[OFF_W +: PAGE_W];
            w_in_offset = w_pm1[OFF_W-1:0];
            w_in_bad    = (i_position == '0)
                       || (w_pm1 > POS_W'(i_sel_len))
                       || (w_pm1[POS_W-1:OFF_W+PAGE_W] != '0);
        end else begin
            // A word sits at position times the word size; the page is the
            // upper part of the position and the word index the lower part.
            w_in_page   = i_position[(OFF_W-WSH) +: PAGE_W];
            w_in_offset = OFF_W'(i_position[OFF_W-WSH-1:0]);
            w_in_bad    = (i_position[POS_W-1:OFF_W-WSH+PAGE_W] != '0);
        end
        w_in_entry = {i_store_kind, i_dict_select, w_in_page};
    end

    // Per-item registers.
    logic [ENTRY_W-1:0] r_entry;
    logic [PAGE_W-1:0]  r_page;
    logic [OFF_W-1:0]   r_offset;
    logic               r_bad;
    logic               r_hit;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_ev_valid;
    logic [ENTRY_W-1:0] r_ev_entry;

    // Buffer state.
    logic [ENTRY_W-1:0] r_owner [NBUF];
    logic [STAMP_W-1:0] r_stamp [NBUF];
    logic [NBUF-1:0]    r_free;
    logic [STAMP_W-1:0] r_counter;

    // LRU scan.
    logic [SLOT_W-1:0]  r_scan;
    logic [STAMP_W-1:0] r_low;

    // Clearing pass.
    logic [ENTRY_W-1:0] r_clr;

    // Page map RAM.
    logic               w_ram_we;
    logic [ENTRY_W-1:0] w_ram_waddr;
    logic [MAP_W-1:0]   w_ram_wdata;
    logic [MAP_W-1:0]   w_ram_rdata;

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_entry;
        w_ram_wdata = '0;
        if (i_cmd.clear_wr) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_clr;
        end else if (i_cmd.unmap) begin
            w_ram_we    = !r_free[r_slot];
            w_ram_waddr = r_owner[r_slot];
        end else if (i_cmd.map) begin
            w_ram_we    = 1'b1;
            w_ram_wdata = {1'b1, r_slot};
        end
    end

    ldpt_ram #(
        .WIDTH (MAP_W),
        .DEPTH (ldpt_pkg::MAP_DEPTH)
    ) u_page_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_in_entry),
        .o_rdata (w_ram_rdata)
    );

    // Hit and slot as seen at completion: straight from the map on a
    // lookup that completes at once, otherwise from the registers.
    logic              w_hit;
    logic [SLOT_W-1:0] w_slot;
    assign w_hit  = i_cmd.lookup ? w_ram_rdata[MAP_W-1] : r_hit;
    assign w_slot = i_cmd.lookup ? w_ram_rdata[SLOT_W-1:0] : r_slot;

    logic w_scan_free;
    logic w_scan_lower;
    assign w_scan_free  = r_free[r_scan];
    assign w_scan_lower = r_stamp[r_scan] < r_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free      <= '1;
            r_counter   <= STAMP_W'(1);
            r_clr       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr <= r_clr + ENTRY_W'(1);
            end
            if (i_cmd.map) begin
                r_free[r_slot] <= 1'b0;
            end
            if (i_cmd.commit && !r_bad) begin
                r_counter <= r_counter + STAMP_W'(1);
            end
            if (i_cmd.commit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_entry    <= w_in_entry;
            r_page     <= w_in_page;
            r_offset   <= w_in_offset;
            r_bad      <= w_in_bad;
            r_ev_valid <= 1'b0;
        end
        if (i_cmd.lookup) begin
            r_hit <= w_ram_rdata[MAP_W-1];
            // A miss starts the scan from buffer zero instead.
            if (!i_cmd.scan_init) begin
                r_slot <= w_ram_rdata[SLOT_W-1:0];
            end
        end
        if (i_cmd.scan_init) begin
            r_scan <= '0;
            r_slot <= '0;
            r_low  <= r_stamp[0];
        end
        if (i_cmd.scan_step) begin
            r_scan <= r_scan + SLOT_W'(1);
            if (w_scan_free) begin
                r_slot <= r_scan;
            end else if (w_scan_lower) begin
                r_slot <= r_scan;
                r_low  <= r_stamp[r_scan];
            end
        end
        if (i_cmd.unmap && !r_free[r_slot]) begin
            r_ev_valid <= 1'b1;
            r_ev_entry <= r_owner[r_slot];
        end
        if (i_cmd.map) begin
            r_owner[r_slot] <= r_entry;
        end
        if (i_cmd.commit) begin
            if (!r_bad) begin
                r_stamp[w_slot] <= r_counter;
            end
            o_out_of_range  <= r_bad;
            o_hit           <= !r_bad && w_hit;
            o_buffer_slot   <= r_bad ? '0 : w_slot;
            o_page_offset   <= r_bad ? '0 : r_offset;
            o_fetch_page    <= (!r_bad && !w_hit) ? r_page : '0;
            o_evicted_valid <= r_ev_valid;
            o_evicted_kind  <= r_ev_valid ? r_ev_entry[ENTRY_W-1] : 1'b0;
            o_evicted_dict  <= r_ev_valid ? r_ev_entry[PAGE_W +: ldpt_pkg::DICT_W] : '0;
            o_evicted_page  <= r_ev_valid ? r_ev_entry[PAGE_W-1:0] : '0;
        end
    end

    always_comb begin
        o_stat.clear_last = &r_clr;
        o_stat.bad        = r_bad;
        o_stat.lookup_hit = w_ram_rdata[MAP_W-1];
        o_stat.scan_done  = w_scan_free || (r_scan == LAST_SLOT);
        o_stat.out_free   = !o_out_valid || i_out_ready;
    end

endmodule

`default_nettype wire

/* src/lru_demand_page_translator_core.sv */
// Top level of the LRU demand page translator: configuration registers and
// the controller/datapath pair. Uses ldpt_pkg, ldpt_ctrl, ldpt_dp.
//
// Usage. Each input item names a store kind (dictionary byte or index word),
// a dictionary and a position. The block splits the position into a page and
// an offset, looks the page up in the page map and returns one result item:
// hit or miss, the buffer that holds the page, the offset, the page to fetch
// on a miss and the page that was unmapped to make room. Byte positions
// outside the dictionary length, and pages beyond the map, are flagged as
// out of range and change no state.
// Both channels use valid/ready. The dictionary length registers sit on an
// APB-style port at byte addresses 0, 4, 8 and 12; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// Timing. A hit or an out-of-range item is read from the page map at the
// accepting edge and goes from the lookup state (or, while the result register
// is full, the finish state) into the result register; the input is ready
// again once it is there. A miss adds an LRU scan (one buffer per cycle, up to
// the first free one or the last buffer), an unmap step and a map step. No new
// item is taken until the current one has reached the result register.
// Reset. After reset a clearing pass writes every one of the 8192 page map
// entries, one per cycle, and no item is accepted until it is done; register
// writes are taken meanwhile.
// Stalls. The result register holds one finished item while the receiver
// stalls; the block still accepts the next item and works on it, and waits
// with that item's result until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module lru_demand_page_translator_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration port.
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ldpt_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [ldpt_pkg::PDATA_W-1:0]      pwdata,
    output logic      [ldpt_pkg::PDATA_W-1:0]      prdata,
    output logic                                   pready,
    // Input channel.
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_store_kind,
    input  wire logic [ldpt_pkg::DICT_W-1:0]       i_dict_select,
    input  wire logic [ldpt_pkg::POS_W-1:0]        i_position,
    // Output channel.
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_of_range,
    output logic                                   o_hit,
    output logic      [ldpt_pkg::SLOT_W-1:0]       o_buffer_slot,
    output logic      [ldpt_pkg::OFFSET_W-1:0]     o_page_offset,
    output logic      [ldpt_pkg::PAGE_W-1:0]       o_fetch_page,
    output logic                                   o_evicted_valid,
    output logic      [ldpt_pkg::DICT_W-1:0]       o_evicted_dict,
    output logic                                   o_evicted_kind,
    output logic      [ldpt_pkg::PAGE_W-1:0]       o_evicted_page
);

    localparam int LEN_W = ldpt_pkg::LEN_W;

    // Dictionary length registers, one per dictionary.
    logic [LEN_W-1:0] r_dict_len [ldpt_pkg::NUM_REGS];
    logic [ldpt_pkg::REG_IDX_W-1:0] w_reg_idx;
    logic w_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ldpt_pkg::PADDR_W-1:2];
    assign w_wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dict_len[ldpt_pkg::REG_DICT_LEN_0] <= '0;
            r_dict_len[ldpt_pkg::REG_DICT_LEN_1] <= '0;
            r_dict_len[ldpt_pkg::REG_DICT_LEN_2] <= '0;
            r_dict_len[ldpt_pkg::REG_DICT_LEN_3] <= '0;
        end else if (w_wr) begin
            r_dict_len[w_reg_idx] <= pwdata[LEN_W-1:0];
        end
    end

    // Reads return the register zero-extended to the bus width.
    assign prdata = ldpt_pkg::PDATA_W'(r_dict_len[w_reg_idx]);

    ldpt_pkg::t_cmd  w_cmd;
    ldpt_pkg::t_stat w_stat;

    assign o_in_ready = w_cmd.in_ready;

    ldpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The length bound of the addressed dictionary feeds the range check.
    ldpt_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_store_kind    (i_store_kind),
        .i_dict_select   (i_dict_select),
        .i_position      (i_position),
        .i_sel_len       (r_dict_len[i_dict_select]),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_out_of_range  (o_out_of_range),
        .o_hit           (o_hit),
        .o_buffer_slot   (o_buffer_slot),
        .o_page_offset   (o_page_offset),
        .o_fetch_page    (o_fetch_page),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_dict  (o_evicted_dict),
        .o_evicted_kind  (o_evicted_kind),
        .o_evicted_page  (o_evicted_page)
    );

endmodule

`default_nettype wire

/* src/ldpt_checker.sv */
// Port-level checker for the page translator and its bind to the top level.
// Uses ldpt_pkg; attaches to lru_demand_page_translator_core.
`timescale 1ns / 1ps
`default_nettype none

module ldpt_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          o_out_of_range,
    input wire logic                          o_hit,
    input wire logic [ldpt_pkg::SLOT_W-1:0]   o_buffer_slot,
    input wire logic [ldpt_pkg::OFFSET_W-1:0] o_page_offset,
    input wire logic [ldpt_pkg::PAGE_W-1:0]   o_fetch_page,
    input wire logic                          o_evicted_valid
);

    // A stalled result stays up, with its hit, slot and fetch page unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hit)
            && $stable(o_buffer_slot) && $stable(o_fetch_page))
        else $error("result changed while stalled");

    // A rejected item carries no translation.
    a_oor_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> !o_hit && !o_evicted_valid
            && o_buffer_slot == '0 && o_page_offset == '0 && o_fetch_page == '0)
        else $error("out-of-range result has translation fields set");

    // A hit neither fetches nor evicts.
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> !o_evicted_valid && o_fetch_page == '0)
        else $error("hit result reports a fetch or an eviction");

    // Reset starts the clearing pass, during which no item is taken.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input accepted right after reset");

endmodule

bind lru_demand_page_translator_core ldpt_checker u_ldpt_checker (.*);

`default_nettype wire

/* bench/lru_demand_page_translator_core_tb.sv */
// Self-checking testbench for lru_demand_page_translator_core: directed and random accesses
// are checked against a behavioral model of the page map and the LRU buffer choice.
// Depends on ldpt_pkg and the lru_demand_page_translator_core RTL.
`timescale 1ns / 1ps

module lru_demand_page_translator_core_tb;

    import ldpt_pkg::*;

    // Largest legal dictionary length bound (2^22 bytes).
    localparam logic [LEN_W-1:0] MAX_DICT_LEN = 23'd4194304;
    // Words held by one page.
    localparam int WORDS_PER_PAGE = PAGE_BYTES / WORD_BYTES;
    // Cycles without any accepted item before the run is declared hung. The clearing
    // pass after reset keeps the input side closed while it writes all 8192 page map entries.
    localparam int WATCHDOG_LIMIT = 40000;
    // Cycles allowed after the last result so that a stray extra result still shows up.
    localparam int SETTLE_CYCLES = 24;

    // One result item as the block should produce it.
    typedef struct packed {
        logic                out_of_range;
        logic                hit;
        logic [SLOT_W-1:0]   buffer_slot;
        logic [OFFSET_W-1:0] page_offset;
        logic [PAGE_W-1:0]   fetch_page;
        logic                evicted_valid;
        logic [DICT_W-1:0]   evicted_dict;
        logic                evicted_kind;
        logic [PAGE_W-1:0]   evicted_page;
    } t_translation;

    // Block inputs, all known from time zero.
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic                i_in_valid = 1'b0;
    logic                i_store_kind = 1'b0;
    logic [DICT_W-1:0]   i_dict_select = '0;
    logic [POS_W-1:0]    i_position = '0;
    logic                i_out_ready = 1'b0;

    // Block outputs.
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_out_of_range;
    logic                o_hit;
    logic [SLOT_W-1:0]   o_buffer_slot;
    logic [OFFSET_W-1:0] o_page_offset;
    logic [PAGE_W-1:0]   o_fetch_page;
    logic                o_evicted_valid;
    logic [DICT_W-1:0]   o_evicted_dict;
    logic                o_evicted_kind;
    logic [PAGE_W-1:0]   o_evicted_page;

    // Model state: page map, buffer owners, LRU stamps and the dictionary bounds.
    bit                  page_resident [MAP_DEPTH];
    logic [SLOT_W-1:0]   page_slot     [MAP_DEPTH];
    int unsigned         slot_owner    [NUM_BUFFERS];
    bit                  slot_free     [NUM_BUFFERS];
    logic [STAMP_W-1:0]  slot_stamp    [NUM_BUFFERS];
    logic [STAMP_W-1:0]  use_count;
    logic [LEN_W-1:0]    dict_len      [NUM_DICTS];

    // Expected results in order of acceptance, oldest first.
    t_translation        pending_translations[$];

    int                  mismatches = 0;
    int                  quiet_cycles = 0;
    // Percent chance per cycle that the sender idles or the receiver stalls.
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    // Page numbers that the random traffic keeps coming back to, so that hits, misses
    // and evictions all occur often.
    int unsigned         hot_page[3];

    lru_demand_page_translator_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_store_kind    (i_store_kind),
        .i_dict_select   (i_dict_select),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_of_range  (o_out_of_range),
        .o_hit           (o_hit),
        .o_buffer_slot   (o_buffer_slot),
        .o_page_offset   (o_page_offset),
        .o_fetch_page    (o_fetch_page),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_dict  (o_evicted_dict),
        .o_evicted_kind  (o_evicted_kind),
        .o_evicted_page  (o_evicted_page)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Puts the model into its post-reset state: nothing mapped, every buffer free,
    // the use counter at one and all dictionary bounds at zero.
    task automatic reset_translator_model();
        for (int e = 0; e < MAP_DEPTH; e++) begin
            page_resident[e] = 1'b0;
            page_slot[e] = '0;
        end
        for (int b = 0; b < NUM_BUFFERS; b++) begin
            slot_owner[b] = 0;
            slot_free[b] = 1'b1;
            slot_stamp[b] = '0;
        end
        use_count = STAMP_W'(1);
        for (int d = 0; d < NUM_DICTS; d++) begin
            dict_len[d] = '0;
        end
    endtask

    // Translates one access and updates the model state the way the block must.
    function automatic t_translation translate_access(input logic kind,
                                                      input logic [DICT_W-1:0] dict,
                                                      input logic [POS_W-1:0] pos);
        t_translation res;
        bit bad;
        bit found_free;
        int unsigned p;
        int unsigned page_num;
        int unsigned offs;
        int unsigned entry;
        int unsigned slot;
        int unsigned old;
        logic [STAMP_W-1:0] oldest;
        res = '0;
        bad = 1'b0;
        page_num = 0;
        offs = 0;
        p = 32'(pos);
        if (kind == KIND_BYTE) begin
            // Byte positions are one-based and must lie within the bound.
            if (p == 0 || p - 1 > dict_len[dict]) begin
                bad = 1'b1;
            end else begin
                page_num = (p - 1) / PAGE_BYTES;
                offs = (p - 1) % PAGE_BYTES;
            end
        end else begin
            page_num = (p * WORD_BYTES) / PAGE_BYTES;
            offs = ((p * WORD_BYTES) % PAGE_BYTES) / WORD_BYTES;
        end
        if (dict >= NUM_DICTS || page_num >= MAX_PAGES) begin
            bad = 1'b1;
        end
        if (bad) begin
            res.out_of_range = 1'b1;
            return res;
        end

        entry = (kind * NUM_DICTS + dict) * MAX_PAGES + page_num;
        if (page_resident[entry]) begin
            slot = 32'(page_slot[entry]);
            res.hit = 1'b1;
        end else begin
            // First free buffer wins; otherwise the lowest stamp, lowest index on a tie.
            slot = 0;
            oldest = slot_stamp[0];
            found_free = 1'b0;
            for (int b = 0; b < NUM_BUFFERS; b++) begin
                if (!found_free) begin
                    if (slot_free[b]) begin
                        slot = b;
                        found_free = 1'b1;
                    end else if (slot_stamp[b] < oldest) begin
                        oldest = slot_stamp[b];
                        slot = b;
                    end
                end
            end
            if (!slot_free[slot]) begin
                old = slot_owner[slot];
                page_resident[old] = 1'b0;
                res.evicted_valid = 1'b1;
                res.evicted_dict = DICT_W'((old / MAX_PAGES) % NUM_DICTS);
                res.evicted_kind = 1'((old / MAX_PAGES) / NUM_DICTS);
                res.evicted_page = PAGE_W'(old % MAX_PAGES);
            end
            slot_free[slot] = 1'b0;
            slot_owner[slot] = entry;
            page_resident[entry] = 1'b1;
            page_slot[entry] = SLOT_W'(slot);
            res.fetch_page = PAGE_W'(page_num);
        end
        slot_stamp[slot] = use_count;
        use_count = use_count + 1'b1;
        res.buffer_slot = SLOT_W'(slot);
        res.page_offset = OFFSET_W'(offs);
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    // Result checking, receiver stalls and the watchdog all live on the clock edge.
    // Outputs are read before this edge's updates land, so each accepted result item
    // is seen exactly as it was presented.
    always @(posedge i_clk) begin
        t_translation want;
        if (o_out_valid && i_out_ready) begin
            if (pending_translations.size() == 0) begin
                mismatches++;
                $display("%0t: result item arrived with no access pending", $time);
            end else begin
                want = pending_translations.pop_front();
                compare_field("out_of_range", 32'(want.out_of_range), 32'(o_out_of_range));
                compare_field("hit", 32'(want.hit), 32'(o_hit));
                compare_field("buffer_slot", 32'(want.buffer_slot), 32'(o_buffer_slot));
                compare_field("page_offset", 32'(want.page_offset), 32'(o_page_offset));
                compare_field("fetch_page", 32'(want.fetch_page), 32'(o_fetch_page));
                compare_field("evicted_valid", 32'(want.evicted_valid),
                              32'(o_evicted_valid));
                compare_field("evicted_dict", 32'(want.evicted_dict), 32'(o_evicted_dict));
                compare_field("evicted_kind", 32'(want.evicted_kind), 32'(o_evicted_kind));
                compare_field("evicted_page", 32'(want.evicted_page), 32'(o_evicted_page));
            end
        end

        // The receiver stalls at random with the current phase's rate.
        i_out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

        // Any accepted item on either channel or the configuration port counts as progress.
        if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)
                || (psel && penable && pwrite && pready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Offers one access item, idling first at the phase's rate, and records the expected
    // result once the block takes it. Valid stays high between back-to-back items.
    task automatic send_access(input logic kind, input logic [DICT_W-1:0] dict,
                               input logic [POS_W-1:0] pos);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_store_kind <= kind;
        i_dict_select <= dict;
        i_position <= pos;
        do @(posedge i_clk); while (!o_in_ready);
        pending_translations.push_back(translate_access(kind, dict, pos));
    endtask

    // Drops valid and waits until every expected result item has been received.
    // It always waits on the clock before it returns, so valid is never lowered
    // and raised again in the same time step.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_translations.size() != 0);
    endtask

    // One APB write: a setup cycle, then an access cycle that completes on pready.
    // The select lines are left high so that writes can follow back to back.
    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [LEN_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        dict_len[idx] = value;
    endtask

    // Rewrites all four dictionary bounds once the block has gone idle.
    task automatic load_dict_lengths(input logic [LEN_W-1:0] len0, input logic [LEN_W-1:0] len1,
                                     input logic [LEN_W-1:0] len2, input logic [LEN_W-1:0] len3);
        wait_for_results();
        write_register(REG_DICT_LEN_0, len0);
        write_register(REG_DICT_LEN_1, len1);
        write_register(REG_DICT_LEN_2, len2);
        write_register(REG_DICT_LEN_3, len3);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // With every bound still at zero only byte position one is inside a dictionary.
    // Word accesses are checked at the first and last page of the map and just past it.
    task automatic test_reset_defaults();
        send_access(KIND_BYTE, 2'd0, 24'd0);
        send_access(KIND_BYTE, 2'd0, 24'd1);
        send_access(KIND_BYTE, 2'd1, 24'd2);
        send_access(KIND_BYTE, 2'd1, 24'd1);
        send_access(KIND_WORD, 2'd2, 24'd0);
        send_access(KIND_WORD, 2'd3, 24'(MAX_PAGES * WORDS_PER_PAGE - 1));
        send_access(KIND_WORD, 2'd3, 24'(MAX_PAGES * WORDS_PER_PAGE));
        send_access(KIND_WORD, 2'd0, 24'hFFFFFF);
    endtask

    // Bounds at both extremes and right at a page boundary. At the largest bound the
    // last legal byte ends page 1023, and one byte further lands beyond the map even
    // though it is still inside the dictionary.
    task automatic test_range_edges();
        load_dict_lengths(MAX_DICT_LEN, '0, 23'd4095, 23'd4096);
        send_access(KIND_BYTE, 2'd0, 24'(MAX_DICT_LEN));
        send_access(KIND_BYTE, 2'd0, 24'(MAX_DICT_LEN) + 24'd1);
        send_access(KIND_BYTE, 2'd0, 24'hFFFFFF);
        send_access(KIND_BYTE, 2'd2, 24'd4096);
        send_access(KIND_BYTE, 2'd2, 24'd4097);
        send_access(KIND_BYTE, 2'd3, 24'd4097);
        send_access(KIND_BYTE, 2'd3, 24'd4098);
        send_access(KIND_BYTE, 2'd1, 24'd1);
    endtask

    // Fills the remaining free buffers with new word pages, forces an eviction and
    // then revisits an older page.
    task automatic test_lru_replacement();
        for (int pg = 1; pg <= 10; pg++) begin
            send_access(KIND_WORD, 2'd1, 24'(pg * WORDS_PER_PAGE + pg));
        end
        send_access(KIND_WORD, 2'd1, 24'(WORDS_PER_PAGE + 7));
    endtask

    // Random accesses: mostly well-formed ones over a small set of hot pages, so that the
    // buffers fill, hit and evict, plus some fully random noise. When asked, the sender
    // holds off halfway through until the block has delivered every pending result.
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct, input bit drain_midway);
        logic kind;
        logic [DICT_W-1:0] dict;
        logic [POS_W-1:0] pos;
        int unsigned page_num;
        int unsigned zero_based;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        hot_page[0] = $urandom_range(MAX_PAGES - 1);
        hot_page[1] = $urandom_range(3);
        hot_page[2] = MAX_PAGES - 1;
        for (int n = 0; n < n_items; n++) begin
            if (drain_midway && n == n_items / 2) begin
                wait_for_results();
            end
            kind = 1'($urandom_range(1));
            dict = DICT_W'($urandom_range(NUM_DICTS - 1));
            if ($urandom_range(9) == 0) begin
                pos = POS_W'($urandom());
            end else begin
                page_num = hot_page[$urandom_range(2)];
                if (kind == KIND_WORD) begin
                    pos = POS_W'(page_num * WORDS_PER_PAGE
                                 + $urandom_range(WORDS_PER_PAGE - 1));
                end else begin
                    // Mostly fold the byte back inside the dictionary; some stay outside.
                    zero_based = page_num * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1);
                    if (zero_based > dict_len[dict] && $urandom_range(4) != 0) begin
                        zero_based = zero_based % (dict_len[dict] + 1);
                    end
                    pos = POS_W'(zero_based + 1);
                end
            end
            send_access(kind, dict, pos);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        reset_translator_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_range_edges();
        test_lru_replacement();

        // Random phases, each under its own bounds and idling pattern.
        load_dict_lengths(MAX_DICT_LEN, MAX_DICT_LEN, MAX_DICT_LEN, MAX_DICT_LEN);
        test_random_traffic(100, 0, 0, 1'b0);
        load_dict_lengths(LEN_W'($urandom_range(MAX_DICT_LEN)),
                          LEN_W'($urandom_range(MAX_DICT_LEN)),
                          LEN_W'($urandom_range(MAX_DICT_LEN)),
                          LEN_W'($urandom_range(MAX_DICT_LEN)));
        test_random_traffic(100, 83, 0, 1'b0);
        load_dict_lengths(LEN_W'($urandom_range(20000)), LEN_W'($urandom_range(20000)),
                          LEN_W'($urandom_range(20000)), LEN_W'($urandom_range(20000)));
        test_random_traffic(100, 0, 83, 1'b0);
        load_dict_lengths(MAX_DICT_LEN, LEN_W'($urandom_range(MAX_DICT_LEN)), MAX_DICT_LEN,
                          LEN_W'($urandom_range(MAX_DICT_LEN)));
        test_random_traffic(100, 35, 35, 1'b1);
        load_dict_lengths('0, MAX_DICT_LEN, LEN_W'($urandom_range(MAX_DICT_LEN)), 23'd4095);
        test_random_traffic(75, 0, 0, 1'b0);

        // Let everything drain, then give a stray extra result time to appear.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_translations.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* lru_demand_page_translator_core.f */
src/ldpt_pkg.sv
src/ldpt_ram.sv
src/ldpt_ctrl.sv
src/ldpt_dp.sv
src/lru_demand_page_translator_core.sv
src/ldpt_checker.sv
bench/lru_demand_page_translator_core_tb.sv
